@@ src/blm_pkg.sv @@
// Shared types, codes and saturating helpers for the Brent line minimizer.
// Used by blm_div, blm_dp, blm_ctrl and brent_line_minimizer.
package blm_pkg;

  localparam int DATA_W        = 32;
  localparam int ITER_W        = 7;
  localparam int MAX_ITER_DEF  = 100;
  localparam int FRAC_BITS_DEF = 16;
  localparam logic [15:0] TOL_RESET = 16'd66;

  typedef logic signed [DATA_W-1:0] fx_t;
  typedef logic signed [65:0]       wide_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_PROBE     = 2'd0,
    ST_CONVERGED = 2'd1,
    ST_ITER_LIM  = 2'd2,
    ST_IGNORED   = 2'd3
  } status_t;

  // Request kinds
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_VALUE = 1'b1;

  // Controller states, one-hot
  typedef enum logic [20:0] {
    S_IDLE   = 21'h000001,
    S_APPLY  = 21'h000002,
    S_LIM    = 21'h000004,
    S_TOL    = 21'h000008,
    S_CONV   = 21'h000010,
    S_PR     = 21'h000020,
    S_PQ     = 21'h000040,
    S_PT1    = 21'h000080,
    S_PT2    = 21'h000100,
    S_PPQ    = 21'h000200,
    S_PM1    = 21'h000400,
    S_PM2    = 21'h000800,
    S_PM3    = 21'h001000,
    S_PTEST  = 21'h002000,
    S_DSTART = 21'h004000,
    S_DIV    = 21'h008000,
    S_PADJ   = 21'h010000,
    S_G1     = 21'h020000,
    S_G2     = 21'h040000,
    S_FIN    = 21'h080000,
    S_RESP   = 21'h100000
  } state_t;

  // Datapath operations
  typedef enum logic [4:0] {
    OP_NONE, OP_IGN, OP_APPLY, OP_LIM, OP_TOL, OP_CONV,
    OP_R, OP_Q, OP_T1, OP_T2, OP_PQ, OP_M1, OP_M2, OP_M3,
    OP_DSTART, OP_PADJ, OP_G1, OP_G2, OP_FIN
  } op_t;

  typedef struct packed {
    logic capture;
    op_t  op;
  } dp_cmd_t;

  typedef struct packed {
    logic ignore;
    logic limit;
    logic conv;
    logic para;
    logic reject;
    logic div_done;
  } dp_sts_t;

  localparam wide_t SAT_MAX = 66'sd2147483647;
  localparam wide_t SAT_MIN = -66'sd2147483648;

  function automatic fx_t sat(input wide_t v);
    fx_t r;
    if (v > SAT_MAX) r = fx_t'(SAT_MAX);
    else if (v < SAT_MIN) r = fx_t'(SAT_MIN);
    else r = v[DATA_W-1:0];
    return r;
  endfunction

  function automatic fx_t sadd(input fx_t a, input fx_t b);
    return sat(wide_t'(a) + wide_t'(b));
  endfunction

  function automatic fx_t ssub(input fx_t a, input fx_t b);
    return sat(wide_t'(a) - wide_t'(b));
  endfunction

  function automatic fx_t sneg(input fx_t a);
    return sat(-wide_t'(a));
  endfunction

  function automatic fx_t sabs(input fx_t a);
    return (a < 0) ? sat(-wide_t'(a)) : a;
  endfunction

endpackage

@@ src/blm_div.sv @@
// Restoring divider, one quotient bit per cycle, on magnitudes.
// Depends on blm_pkg for the data width.
module blm_div #(
  parameter int FRAC_BITS = blm_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [blm_pkg::DATA_W-1:0]           num,
  input  logic [blm_pkg::DATA_W-1:0]           den,
  output logic                                 done,
  output logic [blm_pkg::DATA_W+FRAC_BITS-1:0] quot
);
  localparam int NW = blm_pkg::DATA_W + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0]            acc_r;
  logic [blm_pkg::DATA_W:0] rem_r;
  logic [CW-1:0]            cnt_r;
  logic                     busy_r, done_r;
  logic [blm_pkg::DATA_W:0]   rem_sh;
  logic [blm_pkg::DATA_W+1:0] diff;
  logic                       ge;

  // Shift in the next numerator bit and try a subtract
  always_comb begin
    rem_sh = {rem_r[blm_pkg::DATA_W-1:0], acc_r[NW-1]};
    diff   = {1'b0, rem_sh} - (blm_pkg::DATA_W+2)'(den);
    ge     = !diff[blm_pkg::DATA_W+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Numerator shifts out the top while quotient bits fill the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= NW'(num) << FRAC_BITS;
      rem_r <= '0;
    end else if (busy_r) begin
      acc_r <= {acc_r[NW-2:0], ge};
      rem_r <= ge ? diff[blm_pkg::DATA_W:0] : rem_sh;
    end
  end

  assign done = done_r;
  assign quot = acc_r;

endmodule

@@ src/blm_dp.sv @@
// Datapath: search state, one shared saturating multiplier, divider, result register.
// Depends on blm_pkg and blm_div.
module blm_dp #(
  parameter int MAX_ITER  = blm_pkg::MAX_ITER_DEF,
  parameter int FRAC_BITS = blm_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  blm_pkg::dp_cmd_t  cmd,
  output blm_pkg::dp_sts_t  sts,
  input  logic              req_type,
  input  blm_pkg::fx_t      bracket_a,
  input  blm_pkg::fx_t      bracket_b,
  input  blm_pkg::fx_t      bracket_c,
  input  blm_pkg::fx_t      func_value,
  input  logic              tol_wr,
  input  logic [15:0]       tol_wdata,
  output logic [15:0]       tol_frac,
  output logic [1:0]        status,
  output blm_pkg::fx_t      probe_point,
  output blm_pkg::fx_t      min_point,
  output blm_pkg::fx_t      min_value
);
  localparam int NW = blm_pkg::DATA_W + FRAC_BITS;
  localparam longint CGOLD_L =
    (64'd3819660 * (64'd1 << FRAC_BITS) + 64'd5000000) / 64'd10000000;
  localparam blm_pkg::fx_t CGOLD = blm_pkg::fx_t'(CGOLD_L);

  logic [15:0]  tol_r;
  logic         kind_r;
  blm_pkg::fx_t ia_r, ib_r, ic_r, ifv_r;
  blm_pkg::fx_t a_r, b_r, x_r, w_r, v_r, fx_r, fw_r, fv_r;
  blm_pkg::fx_t d_r, e_r, pend_r, tol1_r, tol2_r;
  blm_pkg::fx_t r_r, q_r, t_r, m_r, p_r;
  logic [blm_pkg::ITER_W-1:0] iter_r, iter_inc;
  logic         active_r;
  logic [1:0]   st_r;
  blm_pkg::fx_t probe_r, minp_r, minv_r;

  // Shared multiplier
  blm_pkg::fx_t        ma, mb, mres;
  logic signed [63:0]  prod, prod_sh;

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      blm_pkg::OP_R:  begin ma = blm_pkg::ssub(x_r, w_r); mb = blm_pkg::ssub(fx_r, fv_r); end
      blm_pkg::OP_Q:  begin ma = blm_pkg::ssub(x_r, v_r); mb = blm_pkg::ssub(fx_r, fw_r); end
      blm_pkg::OP_T1: begin ma = blm_pkg::ssub(x_r, v_r); mb = q_r; end
      blm_pkg::OP_T2: begin ma = blm_pkg::ssub(x_r, w_r); mb = r_r; end
      blm_pkg::OP_M1: begin ma = q_r; mb = e_r; end
      blm_pkg::OP_M2: begin ma = q_r; mb = blm_pkg::ssub(a_r, x_r); end
      blm_pkg::OP_M3: begin ma = q_r; mb = blm_pkg::ssub(b_r, x_r); end
      blm_pkg::OP_G2: begin ma = CGOLD; mb = e_r; end
      default: begin ma = '0; mb = '0; end
    endcase
    prod    = 64'(ma) * 64'(mb);
    prod_sh = prod >>> FRAC_BITS;
    mres    = blm_pkg::sat(blm_pkg::wide_t'(prod_sh));
  end

  // Tolerances from the best point
  logic [47:0]  tprod;
  blm_pkg::fx_t absx, tol1_n, tol2_n;
  always_comb begin
    absx   = blm_pkg::sabs(x_r);
    tprod  = 48'(tol_r) * 48'(absx[30:0]);
    tol1_n = blm_pkg::fx_t'({1'b0, tprod[46:16]}) + 32'sd1;
    tol2_n = blm_pkg::sadd(tol1_n, tol1_n);
  end

  // Midpoint and convergence test, exact
  logic signed [34:0] xm, halfw, dx, adx, lim;
  always_comb begin
    xm    = (35'(a_r) + 35'(b_r)) >>> 1;
    halfw = (35'(b_r) - 35'(a_r)) >>> 1;
    dx    = 35'(x_r) - xm;
    adx   = (dx < 0) ? -dx : dx;
    lim   = 35'(tol2_r) - halfw;
  end

  // Parabolic step acceptance
  blm_pkg::fx_t hm1;
  always_comb begin
    hm1 = blm_pkg::sabs(t_r) >>> 1;
  end

  // Divider on |p| / q
  logic              div_done;
  logic [NW-1:0]     quot;
  blm_pkg::fx_t      pabs;
  assign pabs = (p_r < 0) ? -p_r : p_r;

  blm_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.op == blm_pkg::OP_DSTART),
    .num   (pabs),
    .den   (q_r),
    .done  (div_done),
    .quot  (quot)
  );

  // Quotient with sign, then edge guard
  blm_pkg::wide_t qv;
  blm_pkg::fx_t   dq, ud, stepv, ufin, qr2, q2, pp;
  logic           near;
  always_comb begin
    qv    = (p_r < 0) ? -blm_pkg::wide_t'(quot) : blm_pkg::wide_t'(quot);
    dq    = blm_pkg::sat(qv);
    ud    = blm_pkg::sadd(x_r, dq);
    near  = (blm_pkg::ssub(ud, a_r) < tol2_r) || (blm_pkg::ssub(b_r, ud) < tol2_r);
    stepv = (blm_pkg::sabs(d_r) >= tol1_r) ? d_r :
            ((d_r >= 0) ? tol1_r : blm_pkg::sneg(tol1_r));
    ufin  = blm_pkg::sadd(x_r, stepv);
    qr2   = blm_pkg::ssub(q_r, r_r);
    q2    = blm_pkg::sadd(qr2, qr2);
    pp    = blm_pkg::ssub(t_r, m_r);
  end

  assign iter_inc = iter_r + 1'b1;

  // Status toward the controller
  always_comb begin
    sts.ignore   = (kind_r == blm_pkg::REQ_VALUE) && !active_r;
    sts.limit    = (kind_r == blm_pkg::REQ_VALUE) && active_r &&
                   (iter_inc >= blm_pkg::ITER_W'(MAX_ITER));
    sts.conv     = adx <= lim;
    sts.para     = blm_pkg::sabs(e_r) > tol1_r;
    sts.reject   = (blm_pkg::sabs(p_r) >= hm1) || (p_r <= m_r) || (p_r >= r_r);
    sts.div_done = div_done;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r    <= blm_pkg::TOL_RESET;
      active_r <= 1'b0;
      iter_r   <= '0;
    end else begin
      if (tol_wr) tol_r <= tol_wdata;
      case (cmd.op)
        blm_pkg::OP_APPLY: begin
          if (kind_r == blm_pkg::REQ_START) begin
            active_r <= 1'b1;
            iter_r   <= '0;
          end else begin
            iter_r <= iter_inc;
          end
        end
        blm_pkg::OP_LIM, blm_pkg::OP_CONV: active_r <= 1'b0;
        default: ;
      endcase
    end
  end

  // Capture, search state and result
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= req_type;
      ia_r   <= bracket_a;
      ib_r   <= bracket_b;
      ic_r   <= bracket_c;
      ifv_r  <= func_value;
    end
    case (cmd.op)
      blm_pkg::OP_APPLY: begin
        if (kind_r == blm_pkg::REQ_START) begin
          a_r  <= (ia_r < ic_r) ? ia_r : ic_r;
          b_r  <= (ia_r > ic_r) ? ia_r : ic_r;
          x_r  <= ib_r; w_r <= ib_r; v_r <= ib_r;
          fx_r <= ifv_r; fw_r <= ifv_r; fv_r <= ifv_r;
          d_r  <= '0; e_r <= '0; pend_r <= '0;
        end else if (ifv_r <= fx_r) begin
          if (pend_r >= x_r) a_r <= x_r;
          else b_r <= x_r;
          v_r <= w_r; fv_r <= fw_r;
          w_r <= x_r; fw_r <= fx_r;
          x_r <= pend_r; fx_r <= ifv_r;
        end else begin
          if (pend_r < x_r) a_r <= pend_r;
          else b_r <= pend_r;
          if (ifv_r <= fw_r || w_r == x_r) begin
            v_r <= w_r; fv_r <= fw_r;
            w_r <= pend_r; fw_r <= ifv_r;
          end else if (ifv_r <= fv_r || v_r == x_r || v_r == w_r) begin
            v_r <= pend_r; fv_r <= ifv_r;
          end
        end
      end
      blm_pkg::OP_IGN: begin
        st_r <= blm_pkg::ST_IGNORED; probe_r <= '0; minp_r <= '0; minv_r <= '0;
      end
      blm_pkg::OP_LIM: begin
        st_r <= blm_pkg::ST_ITER_LIM; probe_r <= '0; minp_r <= x_r; minv_r <= fx_r;
      end
      blm_pkg::OP_CONV: begin
        st_r <= blm_pkg::ST_CONVERGED; probe_r <= '0; minp_r <= x_r; minv_r <= fx_r;
      end
      blm_pkg::OP_TOL: begin
        tol1_r <= tol1_n;
        tol2_r <= tol2_n;
      end
      blm_pkg::OP_R:  r_r <= mres;
      blm_pkg::OP_Q:  q_r <= mres;
      blm_pkg::OP_T1: t_r <= mres;
      blm_pkg::OP_T2: m_r <= mres;
      blm_pkg::OP_PQ: begin
        p_r <= (q2 > 0) ? blm_pkg::sneg(pp) : pp;
        q_r <= blm_pkg::sabs(q2);
      end
      blm_pkg::OP_M1: t_r <= mres;
      blm_pkg::OP_M2: m_r <= mres;
      blm_pkg::OP_M3: r_r <= mres;
      blm_pkg::OP_DSTART: e_r <= d_r;
      blm_pkg::OP_PADJ: begin
        if (near) d_r <= (xm >= 35'(x_r)) ? tol1_r : blm_pkg::sneg(tol1_r);
        else d_r <= dq;
      end
      blm_pkg::OP_G1: e_r <= (35'(x_r) >= xm) ? blm_pkg::ssub(a_r, x_r) :
                                               blm_pkg::ssub(b_r, x_r);
      blm_pkg::OP_G2: d_r <= mres;
      blm_pkg::OP_FIN: begin
        pend_r <= ufin;
        st_r <= blm_pkg::ST_PROBE; probe_r <= ufin; minp_r <= '0; minv_r <= '0;
      end
      default: ;
    endcase
  end

  assign tol_frac    = tol_r;
  assign status      = st_r;
  assign probe_point = probe_r;
  assign min_point   = minp_r;
  assign min_value   = minv_r;

endmodule

@@ src/blm_ctrl.sv @@
// Controller: sequences the datapath through update, test, parabolic or golden step.
// Depends on blm_pkg.
module blm_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  output blm_pkg::dp_cmd_t cmd,
  input  blm_pkg::dp_sts_t sts
);
  blm_pkg::state_t state_r, state_nxt;

  // Next state and datapath command
  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.op      = blm_pkg::OP_NONE;
    case (state_r)
      blm_pkg::S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = blm_pkg::S_APPLY;
        end
      end
      blm_pkg::S_APPLY: begin
        if (sts.ignore) begin
          cmd.op    = blm_pkg::OP_IGN;
          state_nxt = blm_pkg::S_RESP;
        end else begin
          cmd.op    = blm_pkg::OP_APPLY;
          state_nxt = sts.limit ? blm_pkg::S_LIM : blm_pkg::S_TOL;
        end
      end
      blm_pkg::S_LIM: begin
        cmd.op    = blm_pkg::OP_LIM;
        state_nxt = blm_pkg::S_RESP;
      end
      blm_pkg::S_TOL: begin
        cmd.op    = blm_pkg::OP_TOL;
        state_nxt = blm_pkg::S_CONV;
      end
      blm_pkg::S_CONV: begin
        if (sts.conv) begin
          cmd.op    = blm_pkg::OP_CONV;
          state_nxt = blm_pkg::S_RESP;
        end else begin
          state_nxt = sts.para ? blm_pkg::S_PR : blm_pkg::S_G1;
        end
      end
      blm_pkg::S_PR:  begin cmd.op = blm_pkg::OP_R;  state_nxt = blm_pkg::S_PQ;  end
      blm_pkg::S_PQ:  begin cmd.op = blm_pkg::OP_Q;  state_nxt = blm_pkg::S_PT1; end
      blm_pkg::S_PT1: begin cmd.op = blm_pkg::OP_T1; state_nxt = blm_pkg::S_PT2; end
      blm_pkg::S_PT2: begin cmd.op = blm_pkg::OP_T2; state_nxt = blm_pkg::S_PPQ; end
      blm_pkg::S_PPQ: begin cmd.op = blm_pkg::OP_PQ; state_nxt = blm_pkg::S_PM1; end
      blm_pkg::S_PM1: begin cmd.op = blm_pkg::OP_M1; state_nxt = blm_pkg::S_PM2; end
      blm_pkg::S_PM2: begin cmd.op = blm_pkg::OP_M2; state_nxt = blm_pkg::S_PM3; end
      blm_pkg::S_PM3: begin cmd.op = blm_pkg::OP_M3; state_nxt = blm_pkg::S_PTEST; end
      blm_pkg::S_PTEST: begin
        state_nxt = sts.reject ? blm_pkg::S_G1 : blm_pkg::S_DSTART;
      end
      blm_pkg::S_DSTART: begin
        cmd.op    = blm_pkg::OP_DSTART;
        state_nxt = blm_pkg::S_DIV;
      end
      blm_pkg::S_DIV: begin
        if (sts.div_done) state_nxt = blm_pkg::S_PADJ;
      end
      blm_pkg::S_PADJ: begin cmd.op = blm_pkg::OP_PADJ; state_nxt = blm_pkg::S_FIN; end
      blm_pkg::S_G1:   begin cmd.op = blm_pkg::OP_G1;   state_nxt = blm_pkg::S_G2;  end
      blm_pkg::S_G2:   begin cmd.op = blm_pkg::OP_G2;   state_nxt = blm_pkg::S_FIN; end
      blm_pkg::S_FIN:  begin cmd.op = blm_pkg::OP_FIN;  state_nxt = blm_pkg::S_RESP; end
      blm_pkg::S_RESP: begin
        if (out_tready) state_nxt = blm_pkg::S_IDLE;
      end
      default: state_nxt = blm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= blm_pkg::S_IDLE;
    else state_r <= state_nxt;
  end

  assign in_tready  = (state_r == blm_pkg::S_IDLE);
  assign out_tvalid = (state_r == blm_pkg::S_RESP);

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("request accepted while a result is pending");

  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == blm_pkg::S_DIV && sts.div_done) |=> (state_r == blm_pkg::S_PADJ))
    else $error("divider finish not followed by step adjust");

  a_ignore_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == blm_pkg::S_APPLY && sts.ignore) |=> (state_r == blm_pkg::S_RESP))
    else $error("idle value request not answered at once");

endmodule

@@ src/brent_line_minimizer.sv @@
// Brent line minimizer top level. A value request with no search active is answered
// as ignored; others pass the iteration limit and convergence tests, then take a golden
// step or a parabolic step through the bit-serial divider.
// One request in flight at a time; next request taken the cycle after the result
// is consumed. Synchronous active-low reset returns to idle with tolerance_frac
// at 66 and no search active.
module brent_line_minimizer #(
  parameter int MAX_ITER  = blm_pkg::MAX_ITER_DEF,
  parameter int FRAC_BITS = blm_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // bracket_a, bracket_b, bracket_c, func_value
  input  logic         in_tuser,   // req_type
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata,  // probe_point, min_point, min_value
  output logic [1:0]   out_tuser,  // status
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [1:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  blm_pkg::dp_cmd_t cmd;
  blm_pkg::dp_sts_t sts;
  logic [15:0]      tol_frac;
  blm_pkg::fx_t     probe_point, min_point, min_value;
  logic             tol_wr;

  // Register write on the access phase
  assign cfg_pready = 1'b1;
  assign tol_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr == 2'd0) ? {16'd0, tol_frac} : 32'd0;

  blm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  blm_dp #(.MAX_ITER(MAX_ITER), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .req_type    (in_tuser),
    .bracket_a   (in_tdata[31:0]),
    .bracket_b   (in_tdata[63:32]),
    .bracket_c   (in_tdata[95:64]),
    .func_value  (in_tdata[127:96]),
    .tol_wr      (tol_wr),
    .tol_wdata   (cfg_pwdata[15:0]),
    .tol_frac    (tol_frac),
    .status      (out_tuser),
    .probe_point (probe_point),
    .min_point   (min_point),
    .min_value   (min_value)
  );

  assign out_tdata = {min_value, min_point, probe_point};

endmodule
